// ===== rtl/core/iirs_pkg.sv =====
// iirs_pkg: shared sizes, command and status codes, and control/status structs
// for the indexed insert/remove sequence unit; no dependencies
package iirs_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned ELEM_W   = 32;
  localparam int unsigned POS_W    = 8;
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned RES_W    = CNT_W + POS_W;

  typedef enum logic [1:0] {
    CMD_READ   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_INSERT = 2'd2,
    CMD_REMOVE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic load;
    logic rd_idx;
    logic rd_shift;
    logic capt;
    logic wr_val_idx;
    logic wr_shift;
    logic ptr_init;
    logic ptr_step;
    logic finish;
  } ctrl_t;

  typedef struct packed {
    cmd_e cmd;
    logic ok;
    logic pending;
    logic out_free;
  } stat_t;

endpackage

// ===== rtl/core/indexed_insert_remove_sequence_unit.sv =====
// indexed_insert_remove_sequence_unit: top level joining sequencer and datapath
// depends on iirs_pkg, iirs_ctrl, iirs_dp
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_stall_o  command_i position_i element_value_i
//   out      output     out_valid_o/out_stall_i element_out_o element_count_o
//                                              is_empty_o status_o
//
// one word at a time: read and overwrite read and capture the entry, a refused request
// goes straight to finish, and insert and remove also read and write each entry moved
// through the memory (at most CAPACITY-1 entries); finish waits on a stalled output register
// reset clears the entry count and control; entries are undefined until written
// input is taken while idle even if the previous result is still held
module indexed_insert_remove_sequence_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     command_i,
  input  logic [iirs_pkg::POS_W-1:0]     position_i,
  input  logic [iirs_pkg::ELEM_W-1:0]    element_value_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [iirs_pkg::ELEM_W-1:0]    element_out_o,
  output logic [iirs_pkg::CNT_W-1:0]     element_count_o,
  output logic                           is_empty_o,
  output logic [1:0]                     status_o
);

  iirs_pkg::ctrl_t ctrl;
  iirs_pkg::stat_t stat;

  iirs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  iirs_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .stat_o          (stat),
    .command_i       (command_i),
    .position_i      (position_i),
    .element_value_i (element_value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .element_out_o   (element_out_o),
    .element_count_o (element_count_o),
    .is_empty_o      (is_empty_o),
    .status_o        (status_o)
  );

endmodule

// ===== rtl/core/iirs_ctrl.sv =====
// iirs_ctrl: one-hot sequencer issuing datapath commands per request
// depends on iirs_pkg
module iirs_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  iirs_pkg::stat_t stat_i,
  output iirs_pkg::ctrl_t ctrl_o
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_CHECK  = 9'b000000010,
    S_CAPT   = 9'b000000100,
    S_LOOP   = 9'b000001000,
    S_SHRD   = 9'b000010000,
    S_SHWR   = 9'b000100000,
    S_INSWR  = 9'b001000000,
    S_FINISH = 9'b010000000,
    S_SPARE  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          state_d     = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!stat_i.ok) begin
          state_d = S_FINISH;
        end else if (stat_i.cmd == iirs_pkg::CMD_INSERT) begin
          ctrl_o.ptr_init = 1'b1;
          state_d         = S_LOOP;
        end else begin
          ctrl_o.rd_idx = 1'b1;
          state_d       = S_CAPT;
        end
      end
      S_CAPT: begin
        ctrl_o.capt = 1'b1;
        case (stat_i.cmd)
          iirs_pkg::CMD_WRITE: begin
            ctrl_o.wr_val_idx = 1'b1;
            state_d           = S_FINISH;
          end
          iirs_pkg::CMD_REMOVE: begin
            ctrl_o.ptr_init = 1'b1;
            state_d         = S_LOOP;
          end
          default: begin
            state_d = S_FINISH;
          end
        endcase
      end
      S_LOOP: begin
        if (stat_i.pending) begin
          state_d = S_SHRD;
        end else if (stat_i.cmd == iirs_pkg::CMD_INSERT) begin
          state_d = S_INSWR;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_SHRD: begin
        ctrl_o.rd_shift = 1'b1;
        state_d         = S_SHWR;
      end
      S_SHWR: begin
        ctrl_o.wr_shift = 1'b1;
        ctrl_o.ptr_step = 1'b1;
        state_d         = S_LOOP;
      end
      S_INSWR: begin
        ctrl_o.wr_val_idx = 1'b1;
        state_d           = S_FINISH;
      end
      S_FINISH: begin
        if (stat_i.out_free) begin
          ctrl_o.finish = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/core/iirs_dp.sv =====
// iirs_dp: request registers, position check, entry memory, shift pointer,
// entry count and output register; depends on iirs_pkg
module iirs_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  iirs_pkg::ctrl_t                ctrl_i,
  output iirs_pkg::stat_t                stat_o,
  input  logic [1:0]                     command_i,
  input  logic [iirs_pkg::POS_W-1:0]     position_i,
  input  logic [iirs_pkg::ELEM_W-1:0]    element_value_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [iirs_pkg::ELEM_W-1:0]    element_out_o,
  output logic [iirs_pkg::CNT_W-1:0]     element_count_o,
  output logic                           is_empty_o,
  output logic [1:0]                     status_o
);

  localparam int unsigned CNT_W = iirs_pkg::CNT_W;
  localparam int unsigned IDX_W = iirs_pkg::IDX_W;
  localparam int unsigned POS_W = iirs_pkg::POS_W;
  localparam int unsigned RES_W = iirs_pkg::RES_W;
  localparam int unsigned EW    = iirs_pkg::ELEM_W;

  logic [EW-1:0]       mem [iirs_pkg::CAPACITY];
  logic [EW-1:0]       rdata_q;
  logic [EW-1:0]       result_q;
  iirs_pkg::cmd_e      req_cmd_q;
  logic [POS_W-1:0]    req_pos_q;
  logic [EW-1:0]       req_val_q;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CNT_W-1:0]    ptr_q;
  logic                out_valid_q;

  logic signed [RES_W-1:0] pos_ext, cnt_ext, res, limit;
  logic                is_ins, is_rem, full, in_range, ok;
  logic [CNT_W-1:0]    idx_c;
  logic [IDX_W-1:0]    idx, raddr, waddr;
  logic [EW-1:0]       wdata;
  logic                wen;
  iirs_pkg::status_e   st_code;

  assign is_ins  = (req_cmd_q == iirs_pkg::CMD_INSERT);
  assign is_rem  = (req_cmd_q == iirs_pkg::CMD_REMOVE);
  assign pos_ext = {{(RES_W-POS_W){req_pos_q[POS_W-1]}}, req_pos_q};
  assign cnt_ext = {{(RES_W-CNT_W){1'b0}}, count_q};
  assign res     = req_pos_q[POS_W-1] ? (cnt_ext + pos_ext) : pos_ext;
  assign limit   = is_ins ? cnt_ext : (cnt_ext - RES_W'(1));
  assign in_range = !res[RES_W-1] && (res <= limit);
  assign full    = is_ins && (count_q == CNT_W'(iirs_pkg::CAPACITY));
  assign ok      = !full && in_range;
  assign idx_c   = res[CNT_W-1:0];
  assign idx     = res[IDX_W-1:0];

  always_comb begin
    if (full) begin
      st_code = iirs_pkg::ST_FULL;
    end else if (!in_range) begin
      st_code = iirs_pkg::ST_RANGE;
    end else begin
      st_code = iirs_pkg::ST_OK;
    end
  end

  assign stat_o.cmd      = req_cmd_q;
  assign stat_o.ok       = ok;
  assign stat_o.pending  = is_ins ? (ptr_q > idx_c) : (ptr_q < count_q);
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  // memory addressing
  always_comb begin
    if (ctrl_i.rd_shift) begin
      raddr = is_ins ? (ptr_q[IDX_W-1:0] - IDX_W'(1)) : ptr_q[IDX_W-1:0];
    end else begin
      raddr = idx;
    end
    wen = ctrl_i.wr_val_idx || ctrl_i.wr_shift;
    if (ctrl_i.wr_shift) begin
      waddr = is_ins ? ptr_q[IDX_W-1:0] : (ptr_q[IDX_W-1:0] - IDX_W'(1));
      wdata = rdata_q;
    end else begin
      waddr = idx;
      wdata = req_val_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_idx || ctrl_i.rd_shift) begin
      rdata_q <= mem[raddr];
    end
    if (wen) begin
      mem[waddr] <= wdata;
    end
  end

  // request, pointer and result registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      req_cmd_q <= iirs_pkg::cmd_e'(command_i);
      req_pos_q <= position_i;
      req_val_q <= element_value_i;
    end
    if (ctrl_i.ptr_init) begin
      ptr_q <= is_ins ? count_q : (idx_c + CNT_W'(1));
    end else if (ctrl_i.ptr_step) begin
      ptr_q <= is_ins ? (ptr_q - CNT_W'(1)) : (ptr_q + CNT_W'(1));
    end
    if (ctrl_i.capt) begin
      result_q <= rdata_q;
    end
  end

  always_comb begin
    count_d = count_q;
    if (ok && is_ins) begin
      count_d = count_q + CNT_W'(1);
    end else if (ok && is_rem) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.finish) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.finish) begin
      element_out_o   <= !ok ? '0 : (is_ins ? req_val_q : result_q);
      element_count_o <= count_d;
      is_empty_o      <= (count_d == '0);
      status_o        <= st_code;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
